// File: design/bedm_pkg.sv
`timescale 1ns / 1ps

package bedm_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int IDX_W           = $clog2(MAX_PATTERN + 1);
  localparam int CELL_W          = 4;
  localparam int CHAR_W          = 8;
  localparam int PAT_CHARS       = 8;
  localparam int PAT_W           = PAT_CHARS * CHAR_W;
  localparam int WORD_INDEX_BITS = 16;
  localparam int LEN_W           = 4;
  localparam int BUDGET_W        = 4;
  localparam int MATCH_W         = 17;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 64;

  localparam logic [CELL_W-1:0]  CELL_MAX    = 4'd15;
  localparam logic [MATCH_W-1:0] MATCH_LIMIT = 17'h10000;

  typedef enum logic [1:0] {
    REG_PATTERN  = 2'd0,
    REG_LENGTH   = 2'd1,
    REG_BUDGET   = 2'd2,
    REG_CAPACITY = 2'd3
  } cfg_reg_e;

  // One item travelling down the row of cells, with the values a cell hands
  // to its right neighbor.
  typedef struct packed {
    logic              valid;
    logic              eow;
    logic              last;
    logic [CHAR_W-1:0] ch;
    logic [CELL_W-1:0] new_val;
    logic [CELL_W-1:0] old_val;
    logic [CELL_W-1:0] word_dist;
  } chain_t;

  function automatic logic [CELL_W-1:0] sat_inc(input logic [CELL_W-1:0] v);
    return (v == CELL_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CELL_W-1:0] min_cell(input logic [CELL_W-1:0] a,
                                                 input logic [CELL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CELL_W-1:0] cell_reset(input logic [IDX_W-1:0] idx);
    if (32'(idx) > 32'(CELL_MAX)) begin
      return CELL_MAX;
    end
    return CELL_W'(idx);
  endfunction

endpackage

// File: design/bedm_if.sv
`timescale 1ns / 1ps

interface bedm_in_if import bedm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              end_of_word;
  logic              last_word;

  modport source (output valid, ch, end_of_word, last_word, input ready);
  modport sink   (input valid, ch, end_of_word, last_word, output ready);
endinterface

interface bedm_out_if import bedm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [CELL_W-1:0]          distance;
  logic [WORD_INDEX_BITS-1:0] word_index;
  logic                       index_stored;
  logic [MATCH_W-1:0]         match_total;

  modport source (output valid, accepted, distance, word_index, index_stored,
                  match_total, input ready);
  modport sink   (input valid, accepted, distance, word_index, index_stored,
                  match_total, output ready);
endinterface

// File: design/bedm_cell.sv
`timescale 1ns / 1ps

module bedm_cell import bedm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [CHAR_W-1:0] pat_i,
  input  logic [IDX_W-1:0]  plen_i,
  input  chain_t            link_i,
  output chain_t            link_o
);

  logic [CELL_W-1:0] row_q, row_d;
  logic              fresh_q, fresh_d;
  chain_t            link_q, link_d;

  logic [CELL_W-1:0] row_cur;
  logic [CELL_W-1:0] del_val, ins_val, sub_val, new_val;

  // A fresh cell holds its reset value, which is its own position.
  assign row_cur = fresh_q ? cell_reset(idx_i) : row_q;

  always_comb begin
    del_val = sat_inc(row_cur);
    ins_val = sat_inc(link_i.new_val);
    sub_val = (pat_i != link_i.ch) ? sat_inc(link_i.old_val) : link_i.old_val;
    new_val = min_cell(min_cell(del_val, ins_val), sub_val);

    link_d  = link_i;
    row_d   = row_q;
    fresh_d = fresh_q;
    if (link_i.valid) begin
      if (link_i.eow) begin
        if (idx_i == plen_i) begin
          link_d.word_dist = row_cur;
        end
        fresh_d = 1'b1;
      end else begin
        link_d.new_val = new_val;
        link_d.old_val = row_cur;
        row_d          = new_val;
        fresh_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= '0;
      fresh_q <= 1'b1;
    end else if (en_i) begin
      link_q  <= link_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  assign link_o = link_q;

endmodule

// File: design/bedm_tally.sv
`timescale 1ns / 1ps

module bedm_tally import bedm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chain_t              link_i,
  input  logic [BUDGET_W-1:0] budget_i,
  input  logic [MATCH_W-1:0]  capacity_i,
  output logic                stall_o,
  bedm_out_if.source          out_o
);

  logic [WORD_INDEX_BITS-1:0] word_count_q, word_count_d;
  logic [MATCH_W-1:0]         match_count_q, match_count_d;

  logic                       out_valid_q;
  logic                       acc_q;
  logic [CELL_W-1:0]          dist_q;
  logic [WORD_INDEX_BITS-1:0] widx_q;
  logic                       stored_q;
  logic [MATCH_W-1:0]         total_q;

  logic               take;
  logic               acc;
  logic               stored;
  logic [MATCH_W-1:0] total;

  // The chain only waits when a finished word reaches its end while the
  // previous result has not been taken.
  assign stall_o = link_i.valid && link_i.eow && out_valid_q && !out_o.ready;
  assign take    = link_i.valid && link_i.eow && !stall_o;

  always_comb begin
    acc    = (CELL_W'(budget_i) >= link_i.word_dist);
    stored = acc && (match_count_q < capacity_i);
    total  = (acc && (match_count_q < MATCH_LIMIT)) ? match_count_q + 1'b1
                                                    : match_count_q;
    word_count_d  = word_count_q;
    match_count_d = match_count_q;
    if (take) begin
      if (link_i.last) begin
        word_count_d  = '0;
        match_count_d = '0;
      end else begin
        if (!(&word_count_q)) begin
          word_count_d = word_count_q + 1'b1;
        end
        match_count_d = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q  <= '0;
      match_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      word_count_q  <= word_count_d;
      match_count_q <= match_count_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q    <= acc;
      dist_q   <= link_i.word_dist;
      widx_q   <= word_count_q;
      stored_q <= stored;
      total_q  <= total;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = acc_q;
  assign out_o.distance     = dist_q;
  assign out_o.word_index   = widx_q;
  assign out_o.index_stored = stored_q;
  assign out_o.match_total  = total_q;

  a_stored_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stored_q |-> acc_q)
    else $error("index stored for a word that was not accepted");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && link_i.last |=> word_count_q == '0 && match_count_q == '0)
    else $error("counters not cleared after the last word");

  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_count_q <= MATCH_LIMIT)
    else $error("match count beyond its limit");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !link_i.last && !acc |=> $stable(match_count_q))
    else $error("match count moved on a rejected word");

endmodule

// File: design/bounded_edit_distance_matcher_core.sv
`timescale 1ns / 1ps

// Bounded edit-distance matcher. Dictionary words stream in one character
// per item and an end-of-word item closes each word; one result item per word
// gives its Levenshtein distance to the configured pattern (saturated at 15),
// whether it is within the edit budget, its index, whether it was stored
// (accepted while the match count is below the capacity), and the running
// match count. The nine cells take one item every cycle unless stalled; the
// end-of-word item passes the nine cell registers and then the tally output
// register. Input ready drops only while an untaken result sits in the output
// register and the next finished word has reached the end of the row.
// Configuration registers sit at byte addresses 0, 8, 16 and 24.

module bounded_edit_distance_matcher_core import bedm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  bedm_in_if.sink           in_i,
  bedm_out_if.source        out_o
);

  logic [PAT_W-1:0]    pattern_q;
  logic [LEN_W-1:0]    plen_q;
  logic [BUDGET_W-1:0] budget_q;
  logic [MATCH_W-1:0]  capacity_q;

  cfg_reg_e            reg_sel;
  logic                wr_en;
  logic [IDX_W-1:0]    plen_eff;
  logic                en;
  logic                stall;

  chain_t              link [MAX_PATTERN+2];
  logic [CHAR_W-1:0]   pat_char [MAX_PATTERN+1];

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      plen_q     <= '0;
      budget_q   <= '0;
      capacity_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN:  pattern_q  <= pwdata[PAT_W-1:0];
        REG_LENGTH:   plen_q     <= pwdata[LEN_W-1:0];
        REG_BUDGET:   budget_q   <= pwdata[BUDGET_W-1:0];
        REG_CAPACITY: capacity_q <= pwdata[MATCH_W-1:0];
        default:      pattern_q  <= pattern_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN:  prdata = DATA_W'(pattern_q);
      REG_LENGTH:   prdata = DATA_W'(plen_q);
      REG_BUDGET:   prdata = DATA_W'(budget_q);
      REG_CAPACITY: prdata = DATA_W'(capacity_q);
      default:      prdata = '0;
    endcase
  end

  // Lengths beyond the row read the last cell.
  assign plen_eff = (32'(plen_q) > MAX_PATTERN) ? IDX_W'(MAX_PATTERN)
                                                : IDX_W'(plen_q);

  assign en         = !stall;
  assign in_i.ready = en;

  // Saturated neighbor values make cell zero count the word's characters.
  always_comb begin
    link[0]         = '0;
    link[0].valid   = in_i.valid && en;
    link[0].eow     = in_i.end_of_word;
    link[0].last    = in_i.last_word;
    link[0].ch      = in_i.ch;
    link[0].new_val = CELL_MAX;
    link[0].old_val = CELL_MAX;
  end

  for (genvar j = 0; j <= MAX_PATTERN; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign pat_char[j] = '0;
    end else if (j - 1 < PAT_CHARS) begin : g_pat
      assign pat_char[j] = pattern_q[CHAR_W*(j-1) +: CHAR_W];
    end else begin : g_zero
      assign pat_char[j] = '0;
    end

    bedm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (IDX_W'(j)),
      .pat_i  (pat_char[j]),
      .plen_i (plen_eff),
      .link_i (link[j]),
      .link_o (link[j+1])
    );
  end

  bedm_tally u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .link_i     (link[MAX_PATTERN+1]),
    .budget_i   (budget_q),
    .capacity_i (capacity_q),
    .stall_o    (stall),
    .out_o      (out_o)
  );

endmodule
